/* rtl/huffman_bit_packer_macros.svh */
// Assertion macros shared by the bit packer RTL.
// Uses the module's clock and reset signals by name; no other dependencies.
`ifndef HUFFMAN_BIT_PACKER_MACROS_SVH
`define HUFFMAN_BIT_PACKER_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define HBP_ASSERT_NOW(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define HBP_ASSERT_NEXT(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

/* rtl/hbp_pkg.sv */
// Shared constants, opcodes and types of the Huffman bit packer.
// No dependencies; hbp_emit and huffman_bit_packer import this package.
package hbp_pkg;

   // Table geometry.
   localparam int MAX_CODE_BITS = 32;
   localparam int TABLE_DEPTH   = 256;
   localparam int SYM_W         = 8;
   localparam int WORD_W        = 32;
   localparam int LEN_W         = 6;
   localparam int ENTRY_W       = WORD_W + LEN_W;

   // Accumulator geometry.
   localparam int BYTE_W    = 8;
   localparam int PEND_W    = BYTE_W - 1;
   localparam int PCNT_W    = 3;
   localparam int ACC_W     = MAX_CODE_BITS + PEND_W;
   localparam int TOTAL_W   = $clog2(ACC_W + 1);
   localparam int BYTES_MAX = (MAX_CODE_BITS + PEND_W) / BYTE_W;
   localparam int OUT_W     = BYTES_MAX * BYTE_W;
   localparam int REM_W     = $clog2(BYTES_MAX + 1);
   localparam int IDX_W     = (BYTES_MAX > 1) ? $clog2(BYTES_MAX) : 1;

   // Opcodes of the request word.
   localparam logic [1:0] OP_LOAD   = 2'd0;
   localparam logic [1:0] OP_ENCODE = 2'd1;
   localparam logic [1:0] OP_FLUSH  = 2'd2;

   // Hand-off from the lookup stage to the output register.
   typedef struct packed {
      logic              valid;
      logic [OUT_W-1:0]  data;
      logic [REM_W-1:0]  count;
      logic              pad;
   } emit_load_type;

endpackage

/* rtl/hbp_req_if.sv */
// Request channel: valid/ready handshake carrying one request word.
// Depends on nothing but the fixed field widths.
interface hbp_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  opcode;
   logic [7:0]  symbol;
   logic [31:0] code_bits;
   logic [5:0]  code_len;

   modport source (output valid, output opcode, output symbol, output code_bits,
                   output code_len, input ready);
   modport sink   (input valid, input opcode, input symbol, input code_bits,
                   input code_len, output ready);
endinterface

/* rtl/hbp_rsp_if.sv */
// Response channel: valid/ready handshake carrying one packed output word.
// Depends on nothing but the fixed field widths.
interface hbp_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       last_of_run;
   logic       padded;

   modport source (output valid, output out_byte, output last_of_run,
                   output padded, input ready);
   modport sink   (input valid, input out_byte, input last_of_run,
                   input padded, output ready);
endinterface

/* rtl/hbp_emit.sv */
// Output register of the bit packer: holds up to BYTES_MAX bytes of one item.
// Depends on hbp_pkg, hbp_rsp_if and the assertion macro header.
`include "huffman_bit_packer_macros.svh"

module hbp_emit (
   input  logic                   clock,
   input  logic                   reset,
   input  hbp_pkg::emit_load_type load,
   output logic                   free,
   hbp_rsp_if.source              rsp_chan
);
   import hbp_pkg::*;

   logic [REM_W-1:0] rem_ff, rem_in;
   logic [OUT_W-1:0] data_ff;
   logic             pad_ff;
   logic             take;
   logic [IDX_W-1:0] idx;

   assign take = rsp_chan.valid && rsp_chan.ready;

   // A new item may enter once the last held word leaves this cycle.
   assign free = (rem_ff == '0) || ((rem_ff == REM_W'(1)) && rsp_chan.ready);

   // Remaining word count.
   always_comb begin
      rem_in = rem_ff;
      if (load.valid) begin
         rem_in = load.count;
      end else if (take) begin
         rem_in = rem_ff - REM_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff <= '0;
      end else begin
         rem_ff <= rem_in;
      end
   end

   // Payload captured with each new item.
   always_ff @(posedge clock) begin
      if (load.valid) begin
         data_ff <= load.data;
         pad_ff  <= load.pad;
      end
   end

   // Highest remaining byte goes out first.
   assign idx                  = IDX_W'(rem_ff - REM_W'(1));
   assign rsp_chan.valid       = (rem_ff != '0);
   assign rsp_chan.out_byte    = data_ff[idx*BYTE_W +: BYTE_W];
   assign rsp_chan.last_of_run = (rem_ff == REM_W'(1));
   assign rsp_chan.padded      = pad_ff;

   `HBP_ASSERT_NOW(a_load_when_free, load.valid, free, "emit: load while words still held")
   `HBP_ASSERT_NOW(a_pad_single, rsp_chan.valid && rsp_chan.padded,
                   rem_ff == REM_W'(1), "emit: padded word is not the only word")
   `HBP_ASSERT_NEXT(a_run_continues, take && (rem_ff > REM_W'(1)) && !load.valid,
                    rsp_chan.valid, "emit: run ended early")
endmodule

/* rtl/huffman_bit_packer.sv */
// Huffman bit packer: a request word loads a code table entry, encodes a symbol
// or flushes the pending bits; each finished byte leaves as one response word.
// The block takes one request per cycle while the output register can accept its
// result. An encode that finishes n bytes (0 to 4) holds the output register, which
// keeps up to four bytes and hands out one byte per response word, until its last
// byte is taken; loads, empty flushes and empty codes put nothing into it. The first
// byte comes from the output register, behind the synchronous table read that feeds
// the lookup stage. Table lengths clear at reset through per-entry valid bits, so
// no clearing pass is needed and requests are taken right after reset.
// Depends on hbp_pkg, hbp_req_if, hbp_rsp_if, hbp_emit and the macro header.
`include "huffman_bit_packer_macros.svh"

module huffman_bit_packer (
   input  logic      clock,
   input  logic      reset,
   hbp_req_if.sink   req_chan,
   hbp_rsp_if.source rsp_chan
);
   import hbp_pkg::*;

   // Code table: word and saturated length per symbol.
   logic [ENTRY_W-1:0]      code_mem [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0]  len_valid_ff;
   logic [ENTRY_W-1:0]      rd_data_ff;
   logic                    rd_valid_ff;

   logic                    s1_valid_ff;
   logic [1:0]              s1_op_ff;
   logic                    s1_advance;
   logic                    req_take;
   logic [LEN_W-1:0]        sat_len;

   logic [PEND_W-1:0]       pend_bits_ff, pend_bits_in;
   logic [PCNT_W-1:0]       pend_cnt_ff, pend_cnt_in;

   logic [LEN_W-1:0]        clen;
   logic [ACC_W-1:0]        acc;
   logic [TOTAL_W-1:0]      total;
   logic [PCNT_W-1:0]       tail;
   logic [ACC_W-1:0]        whole;
   logic [BYTE_W-1:0]       flush_byte;
   logic [3:0]              flush_shift;

   emit_load_type           emit_load;
   logic                    emit_free;

   assign s1_advance     = s1_valid_ff && emit_free;
   assign req_chan.ready = !s1_valid_ff || s1_advance;
   assign req_take       = req_chan.valid && req_chan.ready;
   assign sat_len        = (req_chan.code_len > LEN_W'(MAX_CODE_BITS))
                           ? LEN_W'(MAX_CODE_BITS) : req_chan.code_len;

   // Table write on load, table read on every accepted word.
   always_ff @(posedge clock) begin
      if (req_take && (req_chan.opcode == OP_LOAD)) begin
         code_mem[req_chan.symbol] <= {sat_len, req_chan.code_bits};
      end
      if (req_take) begin
         rd_data_ff <= code_mem[req_chan.symbol];
      end
   end

   // Length valid bits, cleared at reset, read alongside the table.
   always_ff @(posedge clock) begin
      if (reset) begin
         len_valid_ff <= '0;
         rd_valid_ff  <= 1'b0;
      end else if (req_take) begin
         rd_valid_ff <= len_valid_ff[req_chan.symbol];
         if (req_chan.opcode == OP_LOAD) begin
            len_valid_ff[req_chan.symbol] <= 1'b1;
         end
      end
   end

   // Lookup stage control.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         s1_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_op_ff <= req_chan.opcode;
      end
   end

   // Append the code word to the pending bits and split off whole bytes.
   assign clen  = rd_valid_ff ? rd_data_ff[ENTRY_W-1 -: LEN_W] : '0;
   assign acc   = (ACC_W'(pend_bits_ff) << clen)
                | (ACC_W'(rd_data_ff[WORD_W-1:0]) & ((ACC_W'(1) << clen) - ACC_W'(1)));
   assign total = TOTAL_W'(pend_cnt_ff) + TOTAL_W'(clen);
   assign tail  = total[PCNT_W-1:0];
   assign whole = acc >> tail;

   // Flush pads the pending bits with zeros below them.
   assign flush_shift = 4'(BYTE_W) - {1'b0, pend_cnt_ff};
   assign flush_byte  = BYTE_W'({1'b0, pend_bits_ff} << flush_shift);

   // Per-opcode result and accumulator update.
   always_comb begin
      emit_load.valid = 1'b0;
      emit_load.data  = '0;
      emit_load.count = '0;
      emit_load.pad   = 1'b0;
      pend_bits_in    = pend_bits_ff;
      pend_cnt_in     = pend_cnt_ff;
      case (s1_op_ff)
         OP_ENCODE: begin
            emit_load.data  = whole[OUT_W-1:0];
            emit_load.count = REM_W'(total >> 3);
            pend_cnt_in     = tail;
            pend_bits_in    = acc[PEND_W-1:0] & ((PEND_W'(1) << tail) - PEND_W'(1));
         end
         OP_FLUSH: begin
            emit_load.data  = OUT_W'(flush_byte);
            emit_load.count = (pend_cnt_ff != '0) ? REM_W'(1) : '0;
            emit_load.pad   = 1'b1;
            pend_cnt_in     = '0;
            pend_bits_in    = '0;
         end
         default: begin
         end
      endcase
      emit_load.valid = s1_advance && (emit_load.count != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_bits_ff <= '0;
         pend_cnt_ff  <= '0;
      end else if (s1_advance) begin
         pend_bits_ff <= pend_bits_in;
         pend_cnt_ff  <= pend_cnt_in;
      end
   end

   hbp_emit u_emit (
      .clock    (clock),
      .reset    (reset),
      .load     (emit_load),
      .free     (emit_free),
      .rsp_chan (rsp_chan)
   );

   `HBP_ASSERT_NOW(a_stall_blocks, s1_valid_ff && !emit_free, !req_chan.ready,
                   "packer: request taken while lookup stage is stalled")
   `HBP_ASSERT_NEXT(a_flush_clears, s1_advance && (s1_op_ff == OP_FLUSH),
                    pend_cnt_ff == '0, "packer: flush left pending bits")
   `HBP_ASSERT_NEXT(a_load_marks, req_take && (req_chan.opcode == OP_LOAD),
                    len_valid_ff[$past(req_chan.symbol)], "packer: load did not mark entry")
endmodule

/* bench/huffman_bit_packer_test.sv */
`timescale 1ns / 1ps
// Self-checking testbench of the Huffman bit packer: directed and random request words,
// with every response word checked against a behavioral copy of the packing logic.
// Depends on hbp_pkg, hbp_req_if, hbp_rsp_if and huffman_bit_packer.
module huffman_bit_packer_test;
   import hbp_pkg::*;

   // The one opcode that the block ignores.
   localparam logic [1:0] OP_UNUSED = 2'd3;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 20;
   localparam int HOLD_CYCLES  = 200;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [7:0]  symbol;
      logic [31:0] code_bits;
      logic [5:0]  code_len;
   } req_word_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_of_run;
      logic       padded;
   } rsp_word_type;

   logic clock;
   logic reset;

   hbp_req_if req_chan ();
   hbp_rsp_if rsp_chan ();

   huffman_bit_packer i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Mirror of the block's state: code table and bit accumulator.
   logic [31:0] code_word_mirror [TABLE_DEPTH];
   logic [5:0]  code_len_mirror [TABLE_DEPTH];
   logic [6:0]  pending_bits_mirror;
   logic [2:0]  pending_count_mirror;

   // Symbols whose code word has been written; random encodes pick from these.
   bit          symbol_loaded [TABLE_DEPTH];
   logic [7:0]  loaded_symbols [$];

   rsp_word_type expected_bytes [$];
   int          error_count;
   int          cycle_count;
   int          send_idle_pct;
   int          recv_idle_pct;
   int          hold_request;
   int          hold_left;

   // Clock; the single reset at the start of the run comes from the main sequence.
   initial clock = 1'b0;
   always #2 clock = ~clock;

   // Run limit.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // Receiver: random stalls, plus a long hold-off when one is requested.
   initial rsp_chan.ready = 1'b0;
   always @(posedge clock) begin
      if (hold_request != 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   function automatic void check_field(string name, logic [7:0] expv, logic [7:0] actv);
      if (expv !== actv) begin
         $display("%0t: %s mismatch, expected %02h, actual %02h", $time, name, expv, actv);
         error_count++;
      end
   endfunction

   // Each accepted response word is compared with the oldest expected word.
   always @(posedge clock) begin
      rsp_word_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_bytes.size() == 0) begin
            $display("%0t: unexpected response word, expected none, actual %02h last %0b pad %0b",
                     $time, rsp_chan.out_byte, rsp_chan.last_of_run, rsp_chan.padded);
            error_count++;
         end else begin
            want = expected_bytes.pop_front();
            check_field("out_byte", want.out_byte, rsp_chan.out_byte);
            check_field("last_of_run", {7'd0, want.last_of_run}, {7'd0, rsp_chan.last_of_run});
            check_field("padded", {7'd0, want.padded}, {7'd0, rsp_chan.padded});
         end
      end
   end

   // Predicts the bytes one request word causes and updates the mirrored state.
   function automatic void pack_expected(req_word_type w);
      logic [5:0]  clen;
      logic [63:0] mask;
      logic [63:0] acc;
      logic [15:0] shifted;
      int          total;
      int          nbytes;
      rsp_word_type r;
      case (w.opcode)
         OP_LOAD: begin
            code_word_mirror[w.symbol] = w.code_bits;
            code_len_mirror[w.symbol] = (w.code_len > MAX_CODE_BITS) ?
                                        6'(MAX_CODE_BITS) : w.code_len;
            if (!symbol_loaded[w.symbol]) begin
               symbol_loaded[w.symbol] = 1'b1;
               loaded_symbols.push_back(w.symbol);
            end
         end
         OP_ENCODE: begin
            clen = code_len_mirror[w.symbol];
            if (clen != 0) begin
               mask = (64'd1 << clen) - 64'd1;
               acc = ({57'd0, pending_bits_mirror} << clen)
                     | ({32'd0, code_word_mirror[w.symbol]} & mask);
               total = int'(pending_count_mirror) + int'(clen);
               nbytes = total / 8;
               for (int i = 0; i < nbytes; i++) begin
                  total -= 8;
                  r.out_byte = 8'(acc >> total);
                  r.last_of_run = (i == nbytes - 1);
                  r.padded = 1'b0;
                  expected_bytes.push_back(r);
               end
               pending_count_mirror = 3'(total);
               pending_bits_mirror = 7'(acc & ((64'd1 << total) - 64'd1));
            end
         end
         OP_FLUSH: begin
            // Pending bits move to the top of the byte, zeros fill the low side.
            if (pending_count_mirror != 0) begin
               shifted = {9'd0, pending_bits_mirror} << (8 - pending_count_mirror);
               r.out_byte = shifted[7:0];
               r.last_of_run = 1'b1;
               r.padded = 1'b1;
               expected_bytes.push_back(r);
            end
            pending_bits_mirror = '0;
            pending_count_mirror = '0;
         end
         default: begin
         end
      endcase
   endfunction

   function automatic req_word_type make_word(logic [1:0] op, logic [7:0] sym,
                                              logic [31:0] bits, logic [5:0] len);
      req_word_type w;
      w.opcode = op;
      w.symbol = sym;
      w.code_bits = bits;
      w.code_len = len;
      return w;
   endfunction

   // Offers one request word after random idle cycles and waits for it to be taken.
   task automatic send_word(req_word_type w);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.opcode    <= w.opcode;
      req_chan.symbol    <= w.symbol;
      req_chan.code_bits <= w.code_bits;
      req_chan.code_len  <= w.code_len;
      do @(posedge clock); while (!req_chan.ready);
      pack_expected(w);
   endtask

   // Sender pauses until every expected response word has come.
   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (expected_bytes.size() != 0) @(posedge clock);
   endtask

   // Field extremes, saturated and empty codes, empty and padded flushes, unused opcode.
   task automatic test_directed_cases();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      send_word(make_word(OP_LOAD, 8'h00, 32'h0000_0001, 6'd1));
      send_word(make_word(OP_LOAD, 8'hFF, 32'hFFFF_FFFF, 6'd32));
      send_word(make_word(OP_LOAD, 8'h80, 32'hA5A5_5A5A, 6'd63));
      send_word(make_word(OP_LOAD, 8'h01, 32'hFFFF_FFFF, 6'd0));
      send_word(make_word(OP_LOAD, 8'h7F, 32'h0000_0000, 6'd33));
      send_word(make_word(OP_LOAD, 8'h55, 32'h0000_0055, 6'd7));
      send_word(make_word(OP_ENCODE, 8'h00, '0, '0));
      send_word(make_word(OP_ENCODE, 8'hFF, '0, '0));
      send_word(make_word(OP_ENCODE, 8'h01, '0, '0));
      send_word(make_word(OP_ENCODE, 8'h80, '0, '0));
      send_word(make_word(OP_ENCODE, 8'h7F, '0, '0));
      send_word(make_word(OP_ENCODE, 8'h55, '0, '0));
      // A symbol that was never loaded has an empty code.
      send_word(make_word(OP_ENCODE, 8'h02, '0, '0));
      // Accumulator is empty here, so this flush answers nothing.
      send_word(make_word(OP_FLUSH, '0, '0, '0));
      send_word(make_word(OP_ENCODE, 8'h00, '0, '0));
      send_word(make_word(OP_FLUSH, 8'hFF, 32'hFFFF_FFFF, 6'h3F));
      send_word(make_word(OP_UNUSED, 8'hFF, 32'hFFFF_FFFF, 6'h3F));
      // Seven pending bits followed by a full-length code gives four bytes.
      send_word(make_word(OP_ENCODE, 8'h55, '0, '0));
      send_word(make_word(OP_ENCODE, 8'hFF, '0, '0));
      send_word(make_word(OP_FLUSH, '0, '0, '0));
      send_word(make_word(OP_UNUSED, '0, '0, '0));
      send_word(make_word(OP_ENCODE, 8'h55, '0, '0));
      send_word(make_word(OP_FLUSH, '0, '0, '0));
      wait_drained();
   endtask

   // Receiver holds off for a long stretch while long codes keep arriving.
   task automatic test_output_backpressure();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      send_word(make_word(OP_LOAD, 8'hFF, $urandom, 6'd32));
      hold_request = HOLD_CYCLES;
      for (int i = 0; i < 24; i++) send_word(make_word(OP_ENCODE, 8'hFF, '0, '0));
      send_word(make_word(OP_FLUSH, '0, '0, '0));
      wait_drained();
   endtask

   // Random loads, encodes of loaded symbols, flushes and some ignored words.
   task automatic test_random_traffic(int items, int send_pct, int recv_pct);
      int          sent;
      int          pick;
      int          len_pick;
      logic [5:0]  len;
      sent = 0;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      while (sent < items) begin
         pick = $urandom_range(0, 99);
         if (pick < 20) begin
            len_pick = $urandom_range(0, 99);
            if (len_pick < 5) len = 6'd0;
            else if (len_pick < 12) len = 6'($urandom_range(33, 63));
            else if (len_pick < 40) len = 6'($urandom_range(17, 32));
            else len = 6'($urandom_range(1, 16));
            send_word(make_word(OP_LOAD, 8'($urandom), $urandom, len));
            sent++;
         end else if (pick < 85) begin
            send_word(make_word(OP_ENCODE,
                                loaded_symbols[$urandom_range(0, loaded_symbols.size() - 1)],
                                $urandom, 6'($urandom)));
            sent++;
         end else if (pick < 95) begin
            send_word(make_word(OP_FLUSH, 8'($urandom), $urandom, 6'($urandom)));
            sent++;
         end else begin
            send_word(make_word(OP_UNUSED, 8'($urandom), $urandom, 6'($urandom)));
         end
      end
      wait_drained();
   endtask

   // Main sequence.
   initial begin
      reset = 1'b1;
      error_count = 0;
      cycle_count = 0;
      hold_request = 0;
      hold_left = 0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      pending_bits_mirror = '0;
      pending_count_mirror = '0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         code_word_mirror[i] = '0;
         code_len_mirror[i] = '0;
         symbol_loaded[i] = 1'b0;
      end
      req_chan.valid     <= 1'b0;
      req_chan.opcode    <= OP_LOAD;
      req_chan.symbol    <= '0;
      req_chan.code_bits <= '0;
      req_chan.code_len  <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_cases();
      test_output_backpressure();
      test_random_traffic(120, 7, 58);
      test_random_traffic(120, 58, 7);
      test_random_traffic(130, 0, 0);

      // Let any stray response word show up before the verdict.
      req_chan.valid <= 1'b0;
      while (expected_bytes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
